// ----- src/cdrb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular deque package
// Opcodes, field widths and the command and result types shared by the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package cdrb_pkg;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned IN_USER_W = 3;
  localparam int unsigned IN_DATA_W = 32;
  localparam int unsigned RES_W     = 74;
  localparam int unsigned OUT_DATA_W = 80;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - RES_W;

  typedef enum logic [OP_W-1:0] {
    OP_PEEK      = 3'd0,
    OP_INS_FRONT = 3'd1,
    OP_INS_BACK  = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4
  } op_e;

  // Commands from the controller to the datapath, one phase per cycle.
  typedef struct packed {
    logic load_in;
    logic exec;
    logic read;
    logic load_out;
  } dp_cmd_t;

  // Result word; the first member sits in the highest bits.
  typedef struct packed {
    logic [CNT_W-1:0]        entry_count;
    logic                    is_full;
    logic                    is_empty;
    logic                    rear_valid;
    logic signed [VAL_W-1:0] rear_value;
    logic                    front_valid;
    logic signed [VAL_W-1:0] front_value;
    logic                    ok;
  } result_t;

endpackage

// ----- src/cdrb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular deque controller
// Sequences one word through accept, execute, read and output phases and
// owns the output valid flag.
// ----------------------------------------------------------------------------
module cdrb_ctrl import cdrb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_valid_i,
  input  logic    m_ready_i,
  output logic    s_ready_o,
  output logic    m_valid_o,
  output dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e  state_q, state_d;
  logic    m_valid_q, m_valid_d;
  dp_cmd_t cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd.load_in = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_d  = S_READ;
      end
      S_READ: begin
        cmd.read = 1'b1;
        state_d  = S_DONE;
      end
      S_DONE: begin
        // The result register must be empty or draining this cycle.
        if (!m_valid_q || m_ready_i) begin
          cmd.load_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd.load_out) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = m_valid_q;
  assign cmd_o     = cmd;

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && s_ready_o) |=> (state_q == S_EXEC))
    else $error("accepted word did not enter the execute phase");

  a_exec_to_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |=> (state_q == S_READ))
    else $error("execute phase not followed by the read phase");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!m_valid_q || m_ready_i))
    else $error("result register loaded while a word still waits");

endmodule

// ----- src/cdrb_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular deque datapath
// Slot memory, front pointer, entry count, capacity register and the
// registered result word.
// ----------------------------------------------------------------------------
module cdrb_dp import cdrb_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_t                 cmd_i,
  input  logic                    cfg_we_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i,
  input  logic [OP_W-1:0]         in_op_i,
  input  logic signed [VAL_W-1:0] in_data_i,
  output result_t                 result_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned KW = (CW > CFG_W) ? CW : CFG_W;
  localparam int unsigned PW = CW + 1;

  logic signed [VAL_W-1:0] slot_q [DEPTH];

  op_e                     op_q;
  logic signed [VAL_W-1:0] data_q;
  logic [AW-1:0]           front_q, front_d;
  logic [CW-1:0]           count_q, count_d;
  logic [CW-1:0]           cap_q;
  logic                    ok_q, ok_d;
  logic signed [VAL_W-1:0] rd_front_q, rd_rear_q;
  result_t                 res_q;

  logic [KW-1:0] cap_raw, cap_new, count_ext;
  logic          full, empty;
  logic [PW-1:0] front_p, count_p, cap_p;
  logic [PW-1:0] back_sum, inc_sum, rear_sum;
  logic [AW-1:0] dec_front, back_addr, inc_front, rear_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  // Capacity is clamped to 1..DEPTH when written.
  assign cap_raw = KW'(cfg_wdata_i);
  assign cap_new = (cap_raw == '0) ? KW'(1) :
                   (cap_raw > KW'(DEPTH)) ? KW'(DEPTH) : cap_raw;

  assign full  = (count_q >= cap_q);
  assign empty = (count_q == '0);

  assign front_p = PW'(front_q);
  assign count_p = PW'(count_q);
  assign cap_p   = PW'(cap_q);

  // All sums stay below twice the capacity, so one subtract wraps them.
  assign dec_front = (front_q == '0) ? AW'(cap_q - CW'(1)) : front_q - AW'(1);
  assign back_sum  = front_p + count_p;
  assign back_addr = AW'((back_sum >= cap_p) ? back_sum - cap_p : back_sum);
  assign inc_sum   = front_p + PW'(1);
  assign inc_front = AW'((inc_sum >= cap_p) ? inc_sum - cap_p : inc_sum);
  assign rear_sum  = front_p + count_p - PW'(1);
  assign rear_addr = empty ? front_q :
                     AW'((rear_sum >= cap_p) ? rear_sum - cap_p : rear_sum);

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    ok_d    = 1'b0;
    wr_en   = 1'b0;
    wr_addr = back_addr;
    case (op_q)
      OP_PEEK: begin
        ok_d = 1'b1;
      end
      OP_INS_FRONT: begin
        if (!full) begin
          front_d = dec_front;
          wr_addr = dec_front;
          wr_en   = 1'b1;
          count_d = count_q + CW'(1);
          ok_d    = 1'b1;
        end
      end
      OP_INS_BACK: begin
        if (!full) begin
          wr_en   = 1'b1;
          count_d = count_q + CW'(1);
          ok_d    = 1'b1;
        end
      end
      OP_DEL_FRONT: begin
        if (!empty) begin
          front_d = inc_front;
          count_d = count_q - CW'(1);
          ok_d    = 1'b1;
        end
      end
      OP_DEL_BACK: begin
        if (!empty) begin
          count_d = count_q - CW'(1);
          ok_d    = 1'b1;
        end
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      cap_q   <= CW'(DEPTH);
    end else if (cfg_we_i) begin
      front_q <= '0;
      count_q <= '0;
      cap_q   <= CW'(cap_new);
    end else if (cmd_i.exec) begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q   <= op_e'(in_op_i);
      data_q <= in_data_i;
    end
    if (cmd_i.exec) begin
      ok_q <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      slot_q[wr_addr] <= data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rd_front_q <= slot_q[front_q];
      rd_rear_q  <= slot_q[rear_addr];
    end
  end

  assign count_ext = KW'(count_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      res_q.ok          <= ok_q;
      res_q.front_value <= empty ? '0 : rd_front_q;
      res_q.front_valid <= !empty;
      res_q.rear_value  <= empty ? '0 : rd_rear_q;
      res_q.rear_valid  <= !empty;
      res_q.is_empty    <= empty;
      res_q.is_full     <= (count_q == cap_q);
      res_q.entry_count <= count_ext[CNT_W-1:0];
    end
  end

  assign result_o = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q)
    else $error("entry count exceeds capacity");

  a_front_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_p < cap_p)
    else $error("front pointer outside the capacity");

  a_peek_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && (op_q == OP_PEEK) && !cfg_we_i) |=> ($stable(count_q) && $stable(front_q)))
    else $error("peek changed the deque state");

endmodule

// ----- src/circular_deque_ring_buffer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular deque ring buffer core
// Double-ended queue in a ring of DEPTH slots with a run-time capacity.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake                 Contents (low bit up)
//  s_axis    in   tvalid / tready           tuser: opcode[2:0]
//                                           tdata: data_value[31:0]
//  m_axis    out  tvalid / tready           tdata: ok, front_value, front_valid,
//                                           rear_value, rear_valid, is_empty,
//                                           is_full, entry_count, zero pad
//  cfg       in   write enable, no wait     capacity[4:0]
//
// Each word passes through accept, execute (pointer update and slot write),
// slot read of front and rear, then load of the result register. The
// registered read of front and rear follows the slot write of the execute
// phase, so it sees the updated slots and pointers.
// A finished result waits in the output register; the next word is taken
// while it waits, and only the final load stalls if it is still unread.
// Reset clears the pointer, the count and the output valid, and sets the
// capacity to DEPTH. Slot contents are not cleared; unwritten slots are read
// only when empty, masked to zero. A capacity write also empties the deque.
// ----------------------------------------------------------------------------
module circular_deque_ring_buffer_core import cdrb_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input word.
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // data_value[31:0]
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,  // opcode[2:0]
  // Result word.
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // ok[0], front_value[32:1], front_valid[33], rear_value[65:34],
  // rear_valid[66], is_empty[67], is_full[68], entry_count[73:69], zero[79:74]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // Capacity register.
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i
);

  dp_cmd_t cmd;
  result_t result;

  // The controller sequences the phases; the datapath holds all data storage.
  cdrb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .m_ready_i (m_axis_tready_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .cmd_o     (cmd)
  );

  cdrb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_op_i     (s_axis_tuser_i),
    .in_data_i   (s_axis_tdata_i),
    .result_o    (result)
  );

  // The result struct is already laid out with ok in the lowest bit.
  assign m_axis_tdata_o = {{OUT_PAD_W{1'b0}}, result};

endmodule
